/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed at same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed at next-cycle check");

`endif

/* hdl/phpa_pkg.sv */
// ----------------------------------------------------------------------------
// phpa_pkg
// Widths, fixed-point constants and shared types of the pH sample averager.
// ----------------------------------------------------------------------------
package phpa_pkg;

	localparam int unsigned SENSOR_W   = 2;
	localparam int unsigned RAW_W      = 10;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned PH_W       = 16;
	localparam int unsigned MINV_W     = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DEF_SAMPLES = 16;
	localparam int unsigned DEF_SENSORS = 4;

	// register indexes; gains occupy 0 .. sensors-1
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd4096;
	localparam logic [MINV_W-1:0] MIN_VALID_RESET = 5'd3;

	// qualification window on the raw reading
	localparam logic [RAW_W-1:0] RAW_LOW  = 10'd103;
	localparam logic [RAW_W-1:0] RAW_HIGH = 10'd920;
	localparam logic [RAW_W:0]   RAW_MID2 = 11'd1023;

	// k = 5 / (1023 * 0.18) in Q0.16
	localparam int unsigned K_W   = 11;
	localparam logic [K_W-1:0] K_Q16 = 11'd1779;

	localparam int unsigned FRAC_SHIFT = 17;
	localparam logic [PH_W-1:0] PH_MAX_Q12 = 16'd57344;

	// |d| * k and the full |d| * k * gain product
	localparam int unsigned M_W = RAW_W + K_W;
	localparam int unsigned P_W = M_W + GAIN_W;

	// pH 7 in units of 2^-29 pH, and the same plus the rounding half
	localparam int unsigned X_W = 33;
	localparam logic [X_W-1:0] X_SEVEN  = 33'd3758096384;
	localparam logic [X_W-1:0] X_SEVENR = 33'd3758161920;

	typedef struct packed {
		logic              ok;
		logic [RAW_W-1:0]  raw;
		logic [GAIN_W-1:0] gain;
	} conv_req_t;

	typedef struct packed {
		logic            done;
		logic            keep;
		logic [PH_W-1:0] ph;
	} conv_res_t;

endpackage

/* hdl/phpa_convert.sv */
// ----------------------------------------------------------------------------
// phpa_convert
// Qualifies one raw sample and converts it to Q4.12 pH with a bit-serial
// multiply over the gain, one gain bit per cycle.
// ----------------------------------------------------------------------------
module phpa_convert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  phpa_pkg::conv_req_t   req,
	output phpa_pkg::conv_res_t   res
);
	import phpa_pkg::*;

	localparam int unsigned STEP_W = $clog2(GAIN_W);

	typedef enum logic [2:0] {
		CV_IDLE = 3'b001,
		CV_MUL  = 3'b010,
		CV_FIN  = 3'b100
	} cv_state_t;

	cv_state_t          state_q;
	logic [STEP_W-1:0]  step_q;
	logic               ok_q;
	logic               neg_q;
	logic [M_W-1:0]     m_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [M_W-1:0]     hi_q;
	logic [GAIN_W-1:0]  lo_q;
	logic               done_q;
	logic               keep_q;
	logic [PH_W-1:0]    ph_q;

	logic               neg;
	logic [RAW_W:0]     two_raw;
	logic [RAW_W:0]     mag;
	logic [M_W-1:0]     m_full;
	logic               in_window;
	logic [M_W:0]       step_sum;
	logic [P_W-1:0]     prod;
	logic               keep_nx;
	logic [X_W-1:0]     x_rnd;

	always_comb begin
		neg       = req.raw[RAW_W-1];
		two_raw   = {req.raw, 1'b0};
		mag       = neg ? (two_raw - RAW_MID2) : (RAW_MID2 - two_raw);
		m_full    = M_W'(mag[RAW_W-1:0]) * M_W'(K_Q16);
		in_window = (req.raw >= RAW_LOW) && (req.raw <= RAW_HIGH);
		step_sum  = {1'b0, hi_q} + (gain_q[0] ? {1'b0, m_q} : '0);
		prod      = {hi_q, lo_q};
		keep_nx   = ok_q && (prod <= P_W'(X_SEVEN));
		x_rnd     = neg_q ? (X_SEVENR - {1'b0, prod[X_W-2:0]})
		                  : (X_SEVENR + {1'b0, prod[X_W-2:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				CV_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= CV_MUL;
					end
				end
				CV_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(GAIN_W - 1)) begin
						state_q <= CV_FIN;
					end
				end
				CV_FIN: begin
					done_q  <= 1'b1;
					state_q <= CV_IDLE;
				end
				default: state_q <= CV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CV_IDLE && start) begin
			ok_q   <= req.ok && in_window;
			neg_q  <= neg;
			m_q    <= m_full;
			gain_q <= req.gain;
			hi_q   <= '0;
			lo_q   <= '0;
		end else if (state_q == CV_MUL) begin
			// add the partial product, then shift one bit into the low word
			hi_q   <= step_sum[M_W:1];
			lo_q   <= {step_sum[0], lo_q[GAIN_W-1:1]};
			gain_q <= gain_q >> 1;
		end
		if (state_q == CV_FIN) begin
			keep_q <= keep_nx;
			ph_q   <= x_rnd[FRAC_SHIFT +: PH_W];
		end
	end

	assign res.done = done_q;
	assign res.keep = keep_q;
	assign res.ph   = ph_q;

endmodule

/* hdl/phpa_div.sv */
// ----------------------------------------------------------------------------
// phpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phpa_div #(
	parameter int unsigned DW = 20,
	parameter int unsigned VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	import phpa_pkg::*;

	localparam int unsigned CNT_W = $clog2(DW);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     quo_q;
	logic [VW-1:0]     rem_q;
	logic [VW-1:0]     div_q;

	logic [VW:0]       shifted;
	logic [VW+1:0]     diff;
	logic              qbit;

	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		qbit    = !diff[VW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// keep the difference when it does not borrow
			rem_q <= qbit ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/ph_probe_sample_qualify_average.sv */
// ----------------------------------------------------------------------------
// ph_probe_sample_qualify_average
// Qualifies pH-probe ADC samples, converts them to Q4.12 pH and averages
// the kept values over each reading.
// ----------------------------------------------------------------------------
// A sample is accepted, checked against the raw window 103..920, converted by
// a bit-serial multiply (one gain bit per step) and added to the running sum
// if its pH lies in 0..14. The input stays stalled until that sample is added,
// so no new sample is taken before the last is through. The last sample of a
// reading also runs the serial average divider, one quotient bit per cycle
// over the width of the sum (20 bits at 16 samples); the input stays stalled
// through the divide and while a previous result is still stalled in the output
// register. A result waiting on the output does not hold off new samples.
// ----------------------------------------------------------------------------
module ph_probe_sample_qualify_average #(
	parameter int unsigned SAMPLES_PER_READING = phpa_pkg::DEF_SAMPLES,
	parameter int unsigned NUM_SENSORS         = phpa_pkg::DEF_SENSORS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [phpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [phpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [phpa_pkg::SENSOR_W-1:0]     sensor,
	input  logic [phpa_pkg::RAW_W-1:0]        sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [phpa_pkg::PH_W-1:0]         ph,
	output logic                              valid_res,
	output logic [phpa_pkg::SENSOR_W-1:0]     probe
);
	import phpa_pkg::*;

	localparam int unsigned CW  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int unsigned KW  = $clog2(SAMPLES_PER_READING + 1);
	localparam int unsigned SW  = PH_W + $clog2(SAMPLES_PER_READING);
	localparam int unsigned GIW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_DLOAD = 5'b00100,
		S_DIV   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t               state_q;
	logic [GAIN_W-1:0]    gain_q [NUM_SENSORS];
	logic [MINV_W-1:0]    min_valid_q;
	logic [SW-1:0]        sum_q;
	logic [KW-1:0]        kept_q;
	logic [CW-1:0]        cnt_q;
	logic [SENSOR_W-1:0]  sensor_q;
	logic                 out_valid_q;
	logic [PH_W-1:0]      ph_q;
	logic                 valid_res_q;
	logic [SENSOR_W-1:0]  probe_q;

	logic                 accept;
	logic                 sensor_ok;
	conv_req_t            conv_req;
	conv_res_t            conv_res;
	logic                 div_start;
	logic                 div_done;
	logic [SW-1:0]        dividend;
	logic [SW-1:0]        quotient;
	logic                 avg_ok;
	logic                 out_load;
	logic                 last_sample;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		sensor_ok     = ({1'b0, sensor} < (SENSOR_W + 1)'(NUM_SENSORS));
		conv_req.ok   = sensor_ok;
		conv_req.raw  = sample;
		conv_req.gain = sensor_ok ? gain_q[sensor[GIW-1:0]] : '0;
		last_sample   = (cnt_q == CW'(SAMPLES_PER_READING - 1));
		div_start     = (state_q == S_DLOAD);
		dividend      = sum_q + SW'(kept_q >> 1);
		avg_ok        = (kept_q != '0) && (MINV_W'(kept_q) >= min_valid_q);
		out_load      = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	end

	phpa_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.req    (conv_req),
		.res    (conv_res)
	);

	phpa_div #(
		.DW (SW),
		.VW (KW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (kept_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_valid_q <= MIN_VALID_RESET;
			sum_q       <= '0;
			kept_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				gain_q[i] <= GAIN_RESET;
			end
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_MIN_VALID) begin
					min_valid_q <= cfg_data[MINV_W-1:0];
				end else if (cfg_index - REG_GAIN_0 < CFG_IDX_W'(NUM_SENSORS)) begin
					gain_q[cfg_index[GIW-1:0]] <= cfg_data[GAIN_W-1:0];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_res.done) begin
						if (conv_res.keep) begin
							sum_q  <= sum_q + SW'(conv_res.ph);
							kept_q <= kept_q + 1'b1;
						end
						if (last_sample) begin
							state_q <= S_DLOAD;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_DLOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// clear the reading once the result has a place to go
					if (out_load) begin
						sum_q   <= '0;
						kept_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sensor_q <= sensor;
		end
		if (out_load) begin
			ph_q        <= avg_ok ? quotient[PH_W-1:0] : '0;
			valid_res_q <= avg_ok;
			probe_q     <= sensor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ph        = ph_q;
	assign valid_res = valid_res_q;
	assign probe     = probe_q;

endmodule

/* hdl/phpa_checker.sv */
// ----------------------------------------------------------------------------
// phpa_checker
// Port-level checks of the pH sample averager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [phpa_pkg::PH_W-1:0]     ph,
	input logic                          valid_res,
	input logic [phpa_pkg::SENSOR_W-1:0] probe
);
	import phpa_pkg::*;

	// hold a stalled result
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(ph) && $stable(valid_res) && $stable(probe))

	// a rejected reading reports zero
	`ASSERT_SAME(a_invalid_zero, out_valid && !valid_res, ph == '0)

	// an average never leaves the pH range
	`ASSERT_SAME(a_ph_range, out_valid && valid_res, ph <= PH_MAX_Q12)

	// a taken request keeps the input busy while it converts
	`ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

endmodule

bind ph_probe_sample_qualify_average phpa_checker u_phpa_checker (.*);

/* verif/ph_probe_sample_qualify_average_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_probe_sample_qualify_average_tb
// Drives readings of pH-probe samples through the averager under several
// gain and min_valid settings and checks every averaged pH against a
// fixed-point predictor of the qualify, convert and average path.
// ----------------------------------------------------------------------------
module ph_probe_sample_qualify_average_tb;
	import phpa_pkg::*;

	localparam int unsigned CLK_HALF      = 10;
	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned IDLE_PCT      = 13;
	localparam int unsigned QUIET_PERIOD  = 9000;
	localparam int unsigned QUIET_SPAN    = 1800;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned STUCK_LIMIT   = 2000;
	localparam int unsigned TARGET_ITEMS  = 1200;
	localparam int unsigned NUM_REGS      = 1 << CFG_IDX_W;
	localparam int unsigned CNT_W         = $clog2(DEF_SAMPLES);
	localparam int unsigned SUM_W         = PH_W + CNT_W;

	typedef struct {
		logic [SENSOR_W-1:0] sensor;
		logic [RAW_W-1:0]    raw;
	} probe_sample_t;

	typedef struct {
		logic [PH_W-1:0]     ph;
		logic                ok;
		logic [SENSOR_W-1:0] probe;
	} reading_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic [SENSOR_W-1:0]   sensor    = '0;
	logic [RAW_W-1:0]      sample    = '0;
	logic                  out_stall = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic [PH_W-1:0]       ph;
	logic                  valid_res;
	logic [SENSOR_W-1:0]   probe;

	probe_sample_t sample_queue[$];
	reading_t      due_readings[$];
	int unsigned   err_count      = 0;
	int unsigned   cycle_no       = 0;
	int unsigned   stuck_cycles   = 0;
	int unsigned   items_sent     = 0;
	int unsigned   items_accepted = 0;

	// predictor copy of the settings and the running reading
	logic [GAIN_W-1:0] gain_cfg [DEF_SENSORS] = '{default: GAIN_RESET};
	logic [MINV_W-1:0] min_valid_cfg = MIN_VALID_RESET;
	logic [SUM_W-1:0]  ph_sum     = '0;
	logic [CNT_W:0]    kept_count = '0;
	logic [CNT_W-1:0]  taken      = '0;

	logic quiet;
	assign quiet = (cycle_no % QUIET_PERIOD) < QUIET_SPAN;

	ph_probe_sample_qualify_average DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sensor    (sensor),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ph        (ph),
		.valid_res (valid_res),
		.probe     (probe)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < IDLE_PCT);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		err_count++;
	endtask

	// window check, then 7 + d * k * gain in units of 2^-29 pH, kept inside 0..14
	function automatic bit qualify_to_ph(input logic [SENSOR_W-1:0] sen,
			input logic [RAW_W-1:0] raw, output logic [PH_W-1:0] ph_q12);
		longint half_steps;
		longint x;
		longint x_max;
		ph_q12 = '0;
		if (sen >= DEF_SENSORS || raw < RAW_LOW || raw > RAW_HIGH)
			return 1'b0;
		half_steps = longint'(RAW_MID2) - 2 * longint'(raw);
		x = longint'(X_SEVEN) + half_steps * longint'(K_Q16) * longint'(gain_cfg[sen]);
		x_max = longint'(PH_MAX_Q12) <<< FRAC_SHIFT;
		if (x < 0 || x > x_max)
			return 1'b0;
		ph_q12 = PH_W'((x + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT);
		return 1'b1;
	endfunction

	function automatic void absorb_sample(input logic [SENSOR_W-1:0] sen,
			input logic [RAW_W-1:0] raw);
		logic [PH_W-1:0] ph_q12;
		reading_t        avg;
		if (qualify_to_ph(sen, raw, ph_q12)) begin
			ph_sum     = ph_sum + ph_q12;
			kept_count = kept_count + 1'b1;
		end
		if (taken != DEF_SAMPLES - 1) begin
			taken = taken + 1'b1;
			return;
		end
		avg.ok    = kept_count != 0 && kept_count >= min_valid_cfg;
		avg.ph    = avg.ok ? PH_W'((ph_sum + kept_count / 2) / kept_count) : '0;
		avg.probe = sen;
		due_readings.push_back(avg);
		ph_sum     = '0;
		kept_count = '0;
		taken      = '0;
	endfunction

	always @(posedge clk) begin : drive_samples
		probe_sample_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (sample_queue.size() != 0 && !idle_now()) begin
				nxt = sample_queue.pop_front();
				in_valid <= 1'b1;
				sensor   <= nxt.sensor;
				sample   <= nxt.raw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		reading_t want;
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if (in_valid && !in_stall) begin
				absorb_sample(sensor, sample);
				items_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (due_readings.size() == 0) begin
					report_mismatch($sformatf("result with none due: ph %0d valid %0b probe %0d",
						ph, valid_res, probe));
				end else begin
					want = due_readings.pop_front();
					if (ph !== want.ph)
						report_mismatch($sformatf("ph %0d, want %0d", ph, want.ph));
					if (valid_res !== want.ok)
						report_mismatch($sformatf("valid_res %0b, want %0b", valid_res, want.ok));
					if (probe !== want.probe)
						report_mismatch($sformatf("probe %0d, want %0d", probe, want.probe));
				end
			end
			out_stall <= idle_now();
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx < DEF_SENSORS)
			gain_cfg[idx] = value;
		else if (idx == REG_MIN_VALID)
			min_valid_cfg = value[MINV_W-1:0];
	endtask

	// hold until every request is taken and every average is out, then let the pipe drain
	task automatic settle();
		while (items_accepted != items_sent || due_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return GAIN_RESET;
			3: return GAIN_W'($urandom_range(2048, 8192));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	task automatic configure_phase(input int phase);
		logic [GAIN_W-1:0]     g;
		logic [CFG_DATA_W-1:0] mv;
		for (int k = 0; k < DEF_SENSORS; k++) begin
			case (phase)
				0: g = (k == 0) ? '0 : (k == 1) ? '1 : (k == 2) ? GAIN_RESET : 16'h5A5A;
				1: g = GAIN_W'($urandom_range(0, 2048));
				default: g = pick_gain();
			endcase
			write_reg(REG_GAIN_0 + k, g);
		end
		case (phase)
			0: mv = CFG_DATA_W'(1);
			1: mv = CFG_DATA_W'(DEF_SAMPLES);
			2: mv = '0;
			3: mv = {{(CFG_DATA_W - MINV_W){1'b0}}, {MINV_W{1'b1}}};
			default: mv = {(CFG_DATA_W - MINV_W)'($urandom), MINV_W'($urandom_range(0, 20))};
		endcase
		write_reg(REG_MIN_VALID, mv);
		// unmapped indexes must leave the settings alone
		if (phase == 4 || $urandom_range(3) == 0)
			for (int i = REG_MIN_VALID + 1; i < NUM_REGS; i++)
				write_reg(i, CFG_DATA_W'($urandom));
	endtask

	task automatic queue_reading(input int n);
		int unsigned         keep_pct;
		bit                  mixed;
		probe_sample_t       s;
		keep_pct = $urandom_range(100);
		mixed    = $urandom_range(3) == 0;
		s.sensor = SENSOR_W'($urandom_range(DEF_SENSORS - 1));
		for (int i = 0; i < n; i++) begin
			if (mixed)
				s.sensor = SENSOR_W'($urandom_range(DEF_SENSORS - 1));
			if ($urandom_range(19) == 0)
				s.raw = RAW_W'($urandom_range(1023));
			else if ($urandom_range(99) < keep_pct)
				s.raw = RAW_W'($urandom_range(RAW_HIGH, RAW_LOW));
			else if ($urandom_range(1))
				s.raw = RAW_W'($urandom_range(RAW_LOW - 1, 0));
			else
				s.raw = RAW_W'($urandom_range(1023, RAW_HIGH + 1));
			sample_queue.push_back(s);
		end
		items_sent += n;
	endtask

	initial begin : run_phases
		logic [RAW_W-1:0] edge_raws [DEF_SAMPLES];
		probe_sample_t    s;
		int               phase;
		edge_raws = '{10'd0, 10'd1023, 10'd102, 10'd103, 10'd920, 10'd921, 10'd511,
			10'd512, 10'd253, 10'd254, 10'd769, 10'd770, 10'd300, 10'd700, 10'd600,
			10'd400};
		wait (arst_n === 1'b1);
		@(posedge clk);
		// window edges, rail values and the 0 and 14 pH limits, all probes, reset gains
		for (int i = 0; i < DEF_SAMPLES; i++) begin
			s.sensor = SENSOR_W'(i % DEF_SENSORS);
			s.raw    = edge_raws[i];
			sample_queue.push_back(s);
		end
		items_sent += DEF_SAMPLES;
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			settle();
			configure_phase(phase);
			repeat ($urandom_range(5, 8)) queue_reading(DEF_SAMPLES);
			// leave a reading open across the next settings change
			if (phase % 3 == 1)
				queue_reading($urandom_range(1, DEF_SAMPLES - 1));
			phase++;
		end
		settle();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
